FILE: rtl/i2cee_pkg.sv
// ----------------------------------------------------------------------------
// i2cee_pkg
// Types, codes and bus tables shared by the I2C EEPROM master modules.
// ----------------------------------------------------------------------------
package i2cee_pkg;

  localparam int unsigned PAGE_BYTES = 8;

  localparam logic [6:0]  DEVICE_ADDRESS_RST   = 7'd80;
  localparam logic [15:0] PHASE_TICKS_RST      = 16'd25;
  localparam logic [19:0] WRITE_WAIT_TICKS_RST = 20'd5000;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 20;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DEVICE_ADDRESS   = 2'd0,
    CFG_PHASE_TICKS      = 2'd1,
    CFG_WRITE_WAIT_TICKS = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'd0,
    S_ST_A = 5'd1,  S_ST_B = 5'd2,  S_ST_C = 5'd3,
    S_TX_A = 5'd4,  S_TX_B = 5'd5,  S_TX_C = 5'd6,
    S_AK_A = 5'd7,  S_AK_B = 5'd8,  S_AK_C = 5'd9,
    S_RX_A = 5'd10, S_RX_B = 5'd11, S_RX_C = 5'd12,
    S_MA_A = 5'd13, S_MA_B = 5'd14, S_MA_C = 5'd15,
    S_SP_A = 5'd16, S_SP_B = 5'd17, S_SP_C = 5'd18,
    S_WAIT = 5'd19,
    S_NK_C = 5'd20,
    S_FS_A = 5'd21, S_FS_B = 5'd22, S_FS_C = 5'd23
  } step_t;

  typedef enum logic [1:0] {
    DRV_REL = 2'd0,
    DRV_LOW = 2'd1,
    DRV_BIT = 2'd2,
    DRV_ACK = 2'd3
  } drive_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  word_address;
    logic [3:0]  byte_count;
    logic [63:0] write_data;
    logic        sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic       busy_res;
    logic       done_res;
    logic       success;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  device_address;
    logic [15:0] phase_ticks;
    logic [19:0] write_wait_ticks;
  } cfg_t;

  function automatic logic scl_of(step_t s);
    logic v;
    case (s)
      S_ST_C, S_TX_A, S_TX_C, S_AK_A, S_AK_C, S_RX_A, S_RX_C,
      S_MA_A, S_MA_C, S_SP_A, S_NK_C, S_FS_A: v = 1'b0;
      default:                                  v = 1'b1;
    endcase
    return v;
  endfunction

  function automatic drive_t drive_of(step_t s);
    drive_t d;
    case (s)
      S_ST_B, S_ST_C, S_SP_A, S_SP_B, S_FS_A, S_FS_B: d = DRV_LOW;
      S_TX_A, S_TX_B, S_TX_C:                         d = DRV_BIT;
      S_MA_A, S_MA_B, S_MA_C:                         d = DRV_ACK;
      default:                                        d = DRV_REL;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/i2cee_cfg.sv
// ----------------------------------------------------------------------------
// i2cee_cfg
// Configuration registers: device address, phase length and write wait.
// ----------------------------------------------------------------------------
module i2cee_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [i2cee_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [i2cee_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output i2cee_pkg::cfg_t                     cfg
);
  import i2cee_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address   <= DEVICE_ADDRESS_RST;
      cfg_r.phase_ticks      <= PHASE_TICKS_RST;
      cfg_r.write_wait_ticks <= WRITE_WAIT_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEVICE_ADDRESS:   cfg_r.device_address   <= cfg_wdata[6:0];
        CFG_PHASE_TICKS:      cfg_r.phase_ticks      <= cfg_wdata[15:0];
        CFG_WRITE_WAIT_TICKS: cfg_r.write_wait_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/i2cee_seq.sv
// ----------------------------------------------------------------------------
// i2cee_seq
// Bus sequencer: advances the I2C transfer by one tick per transaction and
// forms that tick's result.
// ----------------------------------------------------------------------------
module i2cee_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  i2cee_pkg::in_item_t  in_item,
  input  i2cee_pkg::cfg_t      cfg,
  output i2cee_pkg::out_item_t res
);
  import i2cee_pkg::*;

  step_t       step_r, step_nxt, eff_step;
  logic [19:0] pc_r, pc_nxt, eff_pc;
  logic [3:0]  bit_r, bit_nxt, eff_bit;
  logic [3:0]  byte_r, byte_nxt, eff_byte;
  logic [7:0]  shift_r, shift_nxt, eff_shift;
  logic [63:0] buf_r, buf_nxt, eff_buf;
  logic [7:0]  addr_r, addr_nxt, eff_addr;
  logic [3:0]  cnt_r, cnt_nxt, eff_cnt;
  logic        rd_r, rd_nxt, eff_rd;

  logic        start, active, last_byte, tick_end, wait_on;
  logic [3:0]  cmd_cnt, bit_inc, byte_inc;
  logic [19:0] len;
  logic [20:0] pc_inc;
  logic [7:0]  rx_shift;
  drive_t      drv;

  function automatic logic [7:0] tx_byte(logic [3:0] k, logic rd, logic [6:0] dev,
                                         logic [7:0] a, logic [63:0] b);
    logic [2:0] sel;
    logic [7:0] v;
    sel = 3'(k - 4'd2);
    if (k == 4'd0)      v = {dev, 1'b0};
    else if (k == 4'd1) v = a;
    else if (rd)        v = {dev, 1'b1};
    else                v = b[8*sel +: 8];
    return v;
  endfunction

  // command capture, folded into the tick that accepts it
  always_comb begin
    start = (step_r == S_IDLE) &&
            (in_item.mode == MODE_WRITE || in_item.mode == MODE_READ);
    if (in_item.byte_count == 4'd0)
      cmd_cnt = 4'd1;
    else if (32'(in_item.byte_count) > PAGE_BYTES)
      cmd_cnt = 4'(PAGE_BYTES);
    else
      cmd_cnt = in_item.byte_count;
    if (start) begin
      eff_step  = S_ST_A;
      eff_pc    = '0;
      eff_bit   = '0;
      eff_byte  = '0;
      eff_shift = {cfg.device_address, 1'b0};
      eff_buf   = in_item.write_data;
      eff_addr  = in_item.word_address;
      eff_cnt   = cmd_cnt;
      eff_rd    = (in_item.mode == MODE_READ);
    end else begin
      eff_step  = step_r;
      eff_pc    = pc_r;
      eff_bit   = bit_r;
      eff_byte  = byte_r;
      eff_shift = shift_r;
      eff_buf   = buf_r;
      eff_addr  = addr_r;
      eff_cnt   = cnt_r;
      eff_rd    = rd_r;
    end
  end

  assign active    = start || (step_r != S_IDLE);
  assign last_byte = ({1'b0, eff_byte} == ({1'b0, eff_cnt} + 5'd2));
  assign len       = (eff_step == S_WAIT) ? cfg.write_wait_ticks :
                     (cfg.phase_ticks == 16'd0) ? 20'd1 : {4'b0, cfg.phase_ticks};
  assign pc_inc    = {1'b0, eff_pc} + 21'd1;
  assign tick_end  = !(pc_inc < {1'b0, len});
  assign bit_inc   = eff_bit + 4'd1;
  assign byte_inc  = eff_byte + 4'd1;
  assign rx_shift  = {eff_shift[6:0], in_item.sda_in};
  assign wait_on   = !eff_rd && (cfg.write_wait_ticks != 20'd0);

  // next state
  always_comb begin
    step_nxt  = eff_step;
    pc_nxt    = eff_pc;
    bit_nxt   = eff_bit;
    byte_nxt  = eff_byte;
    shift_nxt = eff_shift;
    buf_nxt   = eff_buf;
    addr_nxt  = eff_addr;
    cnt_nxt   = eff_cnt;
    rd_nxt    = eff_rd;
    if (active) begin
      if (!tick_end) begin
        pc_nxt = pc_inc[19:0];
      end else begin
        pc_nxt = '0;
        case (eff_step)
          S_ST_A: step_nxt = S_ST_B;
          S_ST_B: step_nxt = S_ST_C;
          S_ST_C: begin
            bit_nxt  = '0;
            step_nxt = S_TX_A;
          end
          S_TX_A: step_nxt = S_TX_B;
          S_TX_B: step_nxt = S_TX_C;
          S_TX_C: begin
            shift_nxt = {eff_shift[6:0], 1'b0};
            if (bit_inc >= 4'd8) begin
              bit_nxt  = '0;
              step_nxt = S_AK_A;
            end else begin
              bit_nxt  = bit_inc;
              step_nxt = S_TX_A;
            end
          end
          S_AK_A: step_nxt = S_AK_B;
          S_AK_B: step_nxt = in_item.sda_in ? S_NK_C : S_AK_C;
          S_AK_C: begin
            byte_nxt = byte_inc;
            if (!eff_rd) begin
              if ({1'b0, byte_inc} < ({1'b0, eff_cnt} + 5'd2)) begin
                shift_nxt = tx_byte(byte_inc, eff_rd, cfg.device_address,
                                    eff_addr, eff_buf);
                step_nxt  = S_TX_A;
              end else begin
                step_nxt = S_SP_A;
              end
            end else if (byte_inc == 4'd1) begin
              shift_nxt = tx_byte(byte_inc, eff_rd, cfg.device_address, eff_addr, eff_buf);
              step_nxt  = S_TX_A;
            end else if (byte_inc == 4'd2) begin
              shift_nxt = tx_byte(byte_inc, eff_rd, cfg.device_address, eff_addr, eff_buf);
              step_nxt  = S_ST_A;
            end else begin
              bit_nxt   = '0;
              shift_nxt = '0;
              step_nxt  = S_RX_A;
            end
          end
          S_RX_A: step_nxt = S_RX_B;
          S_RX_B: begin
            shift_nxt = rx_shift;
            bit_nxt   = bit_inc;
            step_nxt  = S_RX_C;
          end
          S_RX_C: step_nxt = (eff_bit >= 4'd8) ? S_MA_A : S_RX_A;
          S_MA_A: step_nxt = S_MA_B;
          S_MA_B: step_nxt = S_MA_C;
          S_MA_C: begin
            if (last_byte) begin
              step_nxt = S_SP_A;
            end else begin
              byte_nxt  = byte_inc;
              bit_nxt   = '0;
              shift_nxt = '0;
              step_nxt  = S_RX_A;
            end
          end
          S_SP_A: step_nxt = S_SP_B;
          S_SP_B: step_nxt = S_SP_C;
          S_SP_C: step_nxt = wait_on ? S_WAIT : S_IDLE;
          S_WAIT: step_nxt = S_IDLE;
          S_NK_C: step_nxt = S_FS_A;
          S_FS_A: step_nxt = S_FS_B;
          S_FS_B: step_nxt = S_FS_C;
          S_FS_C: step_nxt = S_IDLE;
          default: step_nxt = S_IDLE;
        endcase
      end
    end
  end

  // tick result
  always_comb begin
    drv = drive_of(eff_step);
    res = '0;
    res.scl_level = 1'b1;
    if (active) begin
      res.busy_res  = 1'b1;
      res.scl_level = scl_of(eff_step);
      case (drv)
        DRV_LOW: res.sda_pull_low = 1'b1;
        DRV_BIT: res.sda_pull_low = !eff_shift[7];
        DRV_ACK: res.sda_pull_low = !last_byte;
        default: res.sda_pull_low = 1'b0;
      endcase
      if (tick_end) begin
        case (eff_step)
          S_RX_B: begin
            if (bit_inc >= 4'd8) begin
              res.read_valid = 1'b1;
              res.read_byte  = rx_shift;
              res.read_last  = last_byte;
            end
          end
          S_SP_C: begin
            res.done_res = !wait_on;
            res.success  = !wait_on;
          end
          S_WAIT: begin
            res.done_res = 1'b1;
            res.success  = 1'b1;
          end
          S_FS_C: res.done_res = 1'b1;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= S_IDLE;
      pc_r    <= '0;
      bit_r   <= '0;
      byte_r  <= '0;
      shift_r <= '0;
      buf_r   <= '0;
      addr_r  <= '0;
      cnt_r   <= '0;
      rd_r    <= 1'b0;
    end else if (step_en) begin
      step_r  <= step_nxt;
      pc_r    <= pc_nxt;
      bit_r   <= bit_nxt;
      byte_r  <= byte_nxt;
      shift_r <= shift_nxt;
      buf_r   <= buf_nxt;
      addr_r  <= addr_nxt;
      cnt_r   <= cnt_nxt;
      rd_r    <= rd_nxt;
    end
  end

  a_start_enters_start: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && start) |=> (step_r == S_ST_A || step_r == S_ST_B))
    else $error("command did not enter the start condition");

  a_read_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && res.read_valid) |-> (rd_r && step_r == S_RX_B))
    else $error("received byte outside a read transfer");

  a_tx_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == S_TX_A || step_r == S_TX_B || step_r == S_TX_C) |-> (bit_r < 4'd8))
    else $error("transmit bit counter out of range");

endmodule

FILE: rtl/i2cee_oreg.sv
// ----------------------------------------------------------------------------
// i2cee_oreg
// Result register between the sequencer and the output channel.
// ----------------------------------------------------------------------------
module i2cee_oreg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  i2cee_pkg::out_item_t res,
  input  logic                 out_stall,
  output logic                 out_valid,
  output i2cee_pkg::out_item_t out_data,
  output logic                 hold
);
  import i2cee_pkg::*;

  logic      out_valid_r;
  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign hold      = out_valid_r && out_stall;

  a_load_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r)
    else $error("accepted transaction produced no result");

endmodule

FILE: rtl/i2c_eeprom_master_top.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_master_top
// I2C master for a serial EEPROM, page write and random read.
// ----------------------------------------------------------------------------
// Each input transaction is one bus tick and yields exactly one result in the
// cycle after it is taken; a new tick is taken every clock cycle while the
// result register is free or being emptied, so throughput is one tick per
// cycle. The figure is set by the sequencer, which does the whole tick (command
// capture, phase count, step advance, bit shift) combinationally between its
// state registers and the result register. Bus timing is in ticks: every
// SCL/SDA phase lasts phase_ticks ticks and a completed write is followed by
// write_wait_ticks ticks of busy. There is no clearing pass after reset.
module i2c_eeprom_master_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  i2cee_pkg::in_item_t                in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output i2cee_pkg::out_item_t               out_data,
  input  logic                               cfg_we,
  input  logic [i2cee_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [i2cee_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import i2cee_pkg::*;

  cfg_t      cfg;
  out_item_t res;
  logic      accept;
  logic      hold;

  assign in_stall = hold;
  assign accept   = in_valid && !hold;

  i2cee_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  i2cee_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (accept),
    .in_item (in_data),
    .cfg     (cfg),
    .res     (res)
  );

  i2cee_oreg u_oreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .hold      (hold)
  );

endmodule

FILE: sim/i2c_eeprom_master_top_tb.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_master_top_tb
// Self-checking bench for the EEPROM I2C master. Bus ticks are driven through
// the valid/stall input channel. The SDA level of each tick acts as a slave
// that acknowledges, sometimes refuses, and returns random read data. An
// in-bench model of the bus sequencer predicts every tick result, and each
// result is checked field by field. Directed page writes, random reads, NACK
// aborts and command corner cases come first. Randomised traffic follows,
// under several register settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
module i2c_eeprom_master_top_tb;
  import i2cee_pkg::*;

  class eeprom_tick_scoreboard;
    logic [6:0]  dev_addr;
    logic [15:0] phase_len;
    logic [19:0] wait_len;

    step_t       step;
    logic [19:0] ph_cnt;
    logic [3:0]  bit_cnt;
    logic [3:0]  byte_cnt;
    logic [3:0]  count;
    logic [7:0]  shifter;
    logic [7:0]  word_addr;
    logic [63:0] page_data;
    logic        reading;

    out_item_t   due_ticks[$];
    int          errors;
    int          ticks_checked;

    function new();
      dev_addr      = DEVICE_ADDRESS_RST;
      phase_len     = PHASE_TICKS_RST;
      wait_len      = WRITE_WAIT_TICKS_RST;
      step          = S_IDLE;
      ph_cnt        = '0;
      bit_cnt       = '0;
      byte_cnt      = '0;
      count         = '0;
      shifter       = '0;
      word_addr     = '0;
      page_data     = '0;
      reading       = 1'b0;
      errors        = 0;
      ticks_checked = 0;
    endfunction

    function void configure(logic [6:0] dev, logic [15:0] ph, logic [19:0] wt);
      dev_addr  = dev;
      phase_len = ph;
      wait_len  = wt;
    endfunction

    function logic [7:0] tx_byte();
      logic [3:0] k;
      k = byte_cnt - 4'd2;
      if (byte_cnt == 4'd0) return {dev_addr, 1'b0};
      if (byte_cnt == 4'd1) return word_addr;
      if (reading) return {dev_addr, 1'b1};
      return page_data[{k[2:0], 3'b000} +: 8];
    endfunction

    // one bus tick of the sequencer
    function out_item_t sequence_tick(in_item_t t);
      out_item_t   r;
      logic [3:0]  n;
      logic        last;
      int unsigned span;
      r = '0;
      if (step == S_IDLE) begin
        if (t.mode != MODE_WRITE && t.mode != MODE_READ) begin
          r.scl_level = 1'b1;
          return r;
        end
        n = t.byte_count;
        if (n == 4'd0) n = 4'd1;
        if (n > PAGE_BYTES) n = 4'(PAGE_BYTES);
        count     = n;
        word_addr = t.word_address;
        page_data = t.write_data;
        reading   = (t.mode == MODE_READ);
        byte_cnt  = '0;
        bit_cnt   = '0;
        ph_cnt    = '0;
        shifter   = tx_byte();
        step      = S_ST_A;
      end

      last = ({1'b0, byte_cnt} == {1'b0, count} + 5'd2);
      r.busy_res = 1'b1;

      case (step)
        S_ST_C, S_TX_A, S_TX_C, S_AK_A, S_AK_C, S_RX_A, S_RX_C,
        S_MA_A, S_MA_C, S_SP_A, S_NK_C, S_FS_A: r.scl_level = 1'b0;
        default:                                r.scl_level = 1'b1;
      endcase

      case (step)
        S_ST_B, S_ST_C, S_SP_A, S_SP_B, S_FS_A, S_FS_B: r.sda_pull_low = 1'b1;
        S_TX_A, S_TX_B, S_TX_C:                         r.sda_pull_low = !shifter[7];
        S_MA_A, S_MA_B, S_MA_C:                         r.sda_pull_low = !last;
        default:                                        r.sda_pull_low = 1'b0;
      endcase

      span = (step == S_WAIT) ? wait_len : ((phase_len == 16'd0) ? 1 : phase_len);
      if (32'(ph_cnt) + 1 < span) begin
        ph_cnt = ph_cnt + 20'd1;
      end else begin
        ph_cnt = '0;
        case (step)
          S_ST_A: step = S_ST_B;
          S_ST_B: step = S_ST_C;
          S_ST_C: begin
            bit_cnt = '0;
            step    = S_TX_A;
          end
          S_TX_A: step = S_TX_B;
          S_TX_B: step = S_TX_C;
          S_TX_C: begin
            shifter = shifter << 1;
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt >= 4'd8) begin
              bit_cnt = '0;
              step    = S_AK_A;
            end else begin
              step = S_TX_A;
            end
          end
          S_AK_A: step = S_AK_B;
          S_AK_B: step = t.sda_in ? S_NK_C : S_AK_C;
          S_AK_C: begin
            byte_cnt = byte_cnt + 4'd1;
            if (!reading) begin
              if ({1'b0, byte_cnt} < {1'b0, count} + 5'd2) begin
                shifter = tx_byte();
                step    = S_TX_A;
              end else begin
                step = S_SP_A;
              end
            end else if (byte_cnt == 4'd1) begin
              shifter = tx_byte();
              step    = S_TX_A;
            end else if (byte_cnt == 4'd2) begin
              shifter = tx_byte();
              step    = S_ST_A;
            end else begin
              bit_cnt = '0;
              shifter = '0;
              step    = S_RX_A;
            end
          end
          S_RX_A: step = S_RX_B;
          S_RX_B: begin
            shifter = {shifter[6:0], t.sda_in};
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt >= 4'd8) begin
              r.read_valid = 1'b1;
              r.read_byte  = shifter;
              r.read_last  = last;
            end
            step = S_RX_C;
          end
          S_RX_C: step = (bit_cnt >= 4'd8) ? S_MA_A : S_RX_A;
          S_MA_A: step = S_MA_B;
          S_MA_B: step = S_MA_C;
          S_MA_C: begin
            if (last) begin
              step = S_SP_A;
            end else begin
              byte_cnt = byte_cnt + 4'd1;
              bit_cnt  = '0;
              shifter  = '0;
              step     = S_RX_A;
            end
          end
          S_SP_A: step = S_SP_B;
          S_SP_B: step = S_SP_C;
          S_SP_C: begin
            if (!reading && wait_len != 20'd0) begin
              step = S_WAIT;
            end else begin
              r.done_res = 1'b1;
              r.success  = 1'b1;
              step       = S_IDLE;
            end
          end
          S_WAIT: begin
            r.done_res = 1'b1;
            r.success  = 1'b1;
            step       = S_IDLE;
          end
          S_NK_C: step = S_FS_A;
          S_FS_A: step = S_FS_B;
          S_FS_B: step = S_FS_C;
          S_FS_C: begin
            r.done_res = 1'b1;
            r.success  = 1'b0;
            step       = S_IDLE;
          end
          default: step = S_IDLE;
        endcase
      end
      return r;
    endfunction

    function void take_tick(in_item_t t);
      due_ticks.push_back(sequence_tick(t));
    endfunction

    function int pending();
      return due_ticks.size();
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch at result %0d: %s", ticks_checked, msg);
    endfunction

    function void compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endfunction

    function void check_tick(out_item_t got);
      out_item_t want;
      if (due_ticks.size() == 0) begin
        report("result with no transaction outstanding");
        return;
      end
      want = due_ticks.pop_front();
      compare_field("scl_level", 8'(got.scl_level), 8'(want.scl_level));
      compare_field("sda_pull_low", 8'(got.sda_pull_low), 8'(want.sda_pull_low));
      compare_field("read_byte", got.read_byte, want.read_byte);
      compare_field("read_valid", 8'(got.read_valid), 8'(want.read_valid));
      compare_field("read_last", 8'(got.read_last), 8'(want.read_last));
      compare_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
      compare_field("done_res", 8'(got.done_res), 8'(want.done_res));
      compare_field("success", 8'(got.success), 8'(want.success));
      ticks_checked++;
    endfunction
  endclass

  localparam logic [1:0] MODE_SPARE     = 2'd3;
  localparam int         CYCLE_LIMIT    = 4000000;
  localparam int         HOLDOFF_CYCLES = 300;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_item_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_data;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  eeprom_tick_scoreboard sb;

  int cycles         = 0;
  int nack_at        = -1;
  int nack_pct       = 0;
  bit no_write_wait  = 1'b0;
  bit steady         = 1'b0;
  int holdoff_asked  = 0;
  int holdoff_served = 0;
  int stall_left     = 0;
  bit stall_on       = 1'b0;
  int pick;

  i2c_eeprom_master_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: random stall runs, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_tick(out_data);
    if (stall_left == 0) begin
      if (holdoff_served != holdoff_asked) begin
        holdoff_served = holdoff_asked;
        stall_on       = 1'b1;
        stall_left     = HOLDOFF_CYCLES;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          stall_on   = 1'b0;
          stall_left = $urandom_range(1, 8);
        end else if (pick < 65) begin
          stall_on   = 1'b0;
          stall_left = $urandom_range(30, 120);
        end else if (pick < 93) begin
          stall_on   = 1'b1;
          stall_left = $urandom_range(1, 3);
        end else begin
          stall_on   = 1'b1;
          stall_left = $urandom_range(10, 40);
        end
      end
    end
    stall_left = stall_left - 1;
    out_stall <= stall_on;
  end

  // tick built from the sequencer state, with the slave answering on SDA
  function automatic in_item_t make_tick(bit commands);
    in_item_t t;
    int       r;
    r = $urandom_range(0, 99);
    t.byte_count = (r < 70) ? 4'($urandom_range(1, 3)) :
                   (r < 85) ? 4'($urandom_range(4, 8)) : 4'($urandom_range(0, 15));
    t.word_address = 8'($urandom);
    t.write_data   = {$urandom, $urandom};
    if (sb.step != S_AK_B)
      t.sda_in = 1'($urandom_range(0, 1));
    else if (nack_at >= 0)
      t.sda_in = (int'(sb.byte_cnt) == nack_at);
    else if (no_write_wait && !sb.reading)
      t.sda_in = (sb.byte_cnt == sb.count + 4'd1) || ($urandom_range(0, 3) == 0);
    else
      t.sda_in = ($urandom_range(0, 99) < nack_pct);
    r = $urandom_range(0, 99);
    if (sb.step == S_IDLE && commands)
      t.mode = (r < 45) ? MODE_WRITE : (r < 85) ? MODE_READ : (r < 92) ? MODE_SPARE : MODE_TICK;
    else
      t.mode = (r < 80) ? MODE_TICK : (r < 88) ? MODE_SPARE : (r < 94) ? MODE_WRITE : MODE_READ;
    return t;
  endfunction

  task automatic offer_tick(in_item_t t);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    gap = (steady || r < 70) ? 0 : (r < 94) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_tick(t);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic load_config(logic [6:0] dev, logic [15:0] ph, logic [19:0] wt);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEVICE_ADDRESS;
    cfg_wdata <= 20'(dev);
    @(posedge clk);
    cfg_index <= CFG_PHASE_TICKS;
    cfg_wdata <= 20'(ph);
    @(posedge clk);
    cfg_index <= CFG_WRITE_WAIT_TICKS;
    cfg_wdata <= wt;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.configure(dev, ph, wt);
  endtask

  task automatic run_command(logic [1:0] mode, logic [7:0] addr, logic [3:0] n,
                             logic [63:0] data, int nack);
    in_item_t t;
    nack_at = nack;
    t = make_tick(1'b0);
    t.mode         = mode;
    t.word_address = addr;
    t.byte_count   = n;
    t.write_data   = data;
    offer_tick(t);
    while (sb.step != S_IDLE) offer_tick(make_tick(1'b0));
    nack_at = -1;
  endtask

  task automatic random_phase(int ticks, int pause_at, int holdoff_at);
    for (int i = 0; i < ticks; i++) begin
      if (i == pause_at) wait_drained();
      if (i == holdoff_at) begin
        holdoff_asked++;
        steady = 1'b1;
      end else if ($urandom_range(0, 59) == 0) begin
        steady = !steady;
      end
      offer_tick(make_tick(1'b1));
    end
    while (sb.step != S_IDLE) offer_tick(make_tick(1'b0));
    wait_drained();
  endtask

  initial begin
    in_item_t t;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero phase length, no write wait, top device address
    load_config(7'h7f, 16'd0, 20'd0);
    run_command(MODE_WRITE, 8'hff, 4'd9, 64'hffff_ffff_ffff_ffff, -1);
    run_command(MODE_READ, 8'hff, 4'd0, 64'h0, -1);
    run_command(MODE_READ, 8'h00, 4'd15, 64'h0, -1);
    run_command(MODE_SPARE, 8'h55, 4'd2, 64'h0, -1);
    run_command(MODE_TICK, 8'haa, 4'd2, 64'h0, -1);
    run_command(MODE_WRITE, 8'h12, 4'd2, 64'h1234, 0);
    run_command(MODE_WRITE, 8'h56, 4'd3, 64'h0102_0304_0506_0708, 4);
    run_command(MODE_READ, 8'h78, 4'd2, 64'h0, 2);
    wait_drained();

    nack_pct = 4;
    load_config(7'($urandom), 16'd1, 20'($urandom_range(0, 40)));
    random_phase(80, 40, -1);
    load_config(7'($urandom), 16'd2, 20'd0);
    random_phase(80, -1, 5);
    // longest write wait: writes are always refused before it could start
    no_write_wait = 1'b1;
    load_config(7'h7f, 16'd1, 20'hfffff);
    random_phase(80, -1, -1);
    no_write_wait = 1'b0;
    load_config(7'($urandom), 16'd1, 20'($urandom_range(1, 8)));
    random_phase(80, -1, -1);

    // longest phase: idle ticks only
    load_config(7'h00, 16'hffff, 20'd0);
    repeat (20) begin
      t = make_tick(1'b0);
      t.mode = $urandom_range(0, 1) ? MODE_TICK : MODE_SPARE;
      offer_tick(t);
    end
    wait_drained();
    repeat (5) @(posedge clk);

    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
